// ----- sv/qrs_pkg.sv -----
// qrs_pkg: shared types, widths and constants for the QRS detector / heart-rate unit.
// No dependencies; every other file in sv/ except qrs_stream_if refers to it by scoped names.
package qrs_pkg;

    // Sample and score widths
    localparam int SAMPLE_BITS = 16;
    localparam int SCORE_W     = SAMPLE_BITS + 3;

    // Register field widths
    localparam int WARM_W      = 10;
    localparam int WARMCNT_W   = WARM_W + 1;
    localparam int RUN_W       = 4;
    localparam int BPM_W       = 13;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;

    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;
    localparam logic [BPM_W-1:0] BPM_MAX = 13'd8191;

    // Register reset values
    localparam logic [WARM_W-1:0] WARMUP_RST    = 10'd250;
    localparam logic [RUN_W-1:0]  RUN_LEN_RST   = 4'd4;
    localparam logic [BPM_W-1:0]  RATE_LOW_RST  = 13'd80;
    localparam logic [BPM_W-1:0]  RATE_HIGH_RST = 13'd88;

    // Request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARMUP_COUNT = 4'd0,
        CFG_RUN_LENGTH   = 4'd1,
        CFG_RATE_LOW     = 4'd2,
        CFG_RATE_HIGH    = 4'd3
    } cfg_index_e;

    // Request payload
    typedef struct packed {
        logic                          req_type;
        logic signed [SAMPLE_BITS-1:0] sample;
    } req_t;

    // Result payload
    typedef struct packed {
        logic             beat;
        logic             rate_valid;
        logic [BPM_W-1:0] rate_bpm;
        logic             rate_low_flag;
        logic             rate_high_flag;
    } res_t;

    // Register write payload
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

    // Live register contents
    typedef struct packed {
        logic [WARM_W-1:0] warmup_count;
        logic [RUN_W-1:0]  run_length;
        logic [BPM_W-1:0]  rate_low;
        logic [BPM_W-1:0]  rate_high;
    } cfg_regs_t;

    // Rate meter result for a tick
    typedef struct packed {
        logic             valid;
        logic [BPM_W-1:0] bpm;
        logic             low_flag;
        logic             high_flag;
    } rate_res_t;

endpackage

// ----- sv/qrs_stream_if.sv -----
// qrs_stream_if: valid/ready channel carrying one payload of type T per transaction.
// Depends on nothing; payload types come from qrs_pkg at the instantiation site.
interface qrs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/qrs_score.sv -----
// qrs_score: Ahlstrom-Tompkins score of a five-sample window (combinational).
// Depends on qrs_pkg for sample and score widths.
module qrs_score (
    input  logic signed [qrs_pkg::SAMPLE_BITS-1:0] x0,
    input  logic signed [qrs_pkg::SAMPLE_BITS-1:0] x1,
    input  logic signed [qrs_pkg::SAMPLE_BITS-1:0] x2,
    input  logic signed [qrs_pkg::SAMPLE_BITS-1:0] x3,
    input  logic signed [qrs_pkg::SAMPLE_BITS-1:0] x4,
    output logic        [qrs_pkg::SCORE_W-1:0]     score
);
    localparam int SB = qrs_pkg::SAMPLE_BITS;
    localparam int SW = qrs_pkg::SCORE_W;

    logic signed [SB:0]   d20, d31, d42;
    logic        [SB:0]   a20, a31, a42;
    logic signed [SB+1:0] lap;
    logic        [SB+1:0] alap_w;
    logic        [SB+1:0] alap;

    // First differences, each across two sample intervals
    assign d20 = (SB+1)'(x2) - (SB+1)'(x0);
    assign d31 = (SB+1)'(x3) - (SB+1)'(x1);
    assign d42 = (SB+1)'(x4) - (SB+1)'(x2);

    assign a20 = d20[SB] ? (SB+1)'(-d20) : (SB+1)'(d20);
    assign a31 = d31[SB] ? (SB+1)'(-d31) : (SB+1)'(d31);
    assign a42 = d42[SB] ? (SB+1)'(-d42) : (SB+1)'(d42);

    // Second difference over the window; magnitude needs SB+2 bits
    assign lap    = (SB+2)'(x0) - ((SB+2)'(x2) <<< 1) + (SB+2)'(x4);
    assign alap_w = lap[SB+1] ? (SB+2)'(-lap) : (SB+2)'(lap);
    assign alap   = alap_w;

    // 1-2-1 smoothed slope plus curvature
    assign score = SW'(a20) + (SW'(a31) << 1) + SW'(a42) + SW'(alap);

endmodule

// ----- sv/qrs_detect.sv -----
// qrs_detect: sample window, running peak, warm-up and arm/run beat detection.
// Depends on qrs_pkg and instantiates qrs_score.
module qrs_detect (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   step,
    input  logic signed [qrs_pkg::SAMPLE_BITS-1:0] sample,
    input  qrs_pkg::cfg_regs_t                     cfg,
    output logic                                   beat
);
    localparam int SB = qrs_pkg::SAMPLE_BITS;
    localparam int SW = qrs_pkg::SCORE_W;

    logic signed [SB-1:0] win_reg [4];
    logic signed [SB-1:0] win_next [4];
    logic [2:0]                      fill_reg, fill_next;
    logic [qrs_pkg::WARMCNT_W-1:0]   warm_reg, warm_next;
    logic [SW-1:0]                   peak_reg, peak_next;
    logic                            armed_reg, armed_next;
    logic [qrs_pkg::RUN_W-1:0]       run_reg, run_next;

    logic [SW-1:0]   score;
    logic [SW-1:0]   peak_upd;
    logic [SW+3:0]   score10;
    logic [SW+3:0]   peak8;
    logic            low_ok;
    logic            high_ok;
    logic [qrs_pkg::RUN_W-1:0] run_inc;

    qrs_score u_score (
        .x0    (win_reg[0]),
        .x1    (win_reg[1]),
        .x2    (win_reg[2]),
        .x3    (win_reg[3]),
        .x4    (sample),
        .score (score)
    );

    // Thresholds: 10*S against 8*M and M, M already including S
    assign peak_upd = (score > peak_reg) ? score : peak_reg;
    assign score10  = ((SW+4)'(score) << 3) + ((SW+4)'(score) << 1);
    assign peak8    = (SW+4)'(peak_upd) << 3;
    assign low_ok   = score10 >= (SW+4)'(peak_upd);
    assign high_ok  = score10 >= peak8;
    assign run_inc  = (run_reg == qrs_pkg::RUN_MAX) ? run_reg : run_reg + 1'b1;

    // Next state and beat decision
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            win_next[i] = win_reg[i];
        end
        fill_next  = fill_reg;
        warm_next  = warm_reg;
        peak_next  = peak_reg;
        armed_next = armed_reg;
        run_next   = run_reg;
        beat       = 1'b0;

        if (fill_reg < 3'd4)
        begin
            // Window still filling: store only
            win_next[fill_reg[1:0]] = sample;
            fill_next = fill_reg + 1'b1;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[3] = sample;
            peak_next   = peak_upd;

            if (warm_reg <= qrs_pkg::WARMCNT_W'(cfg.warmup_count))
            begin
                warm_next = warm_reg + 1'b1;
            end
            else if (low_ok && armed_reg)
            begin
                run_next = run_inc;
                if (run_inc == cfg.run_length)
                begin
                    beat       = 1'b1;
                    run_next   = '0;
                    armed_next = 1'b0;
                end
            end
            else
            begin
                run_next   = '0;
                armed_next = high_ok;
            end
        end
    end

    // State registers, updated once per sample transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= '0;
            end
            fill_reg  <= '0;
            warm_reg  <= '0;
            peak_reg  <= '0;
            armed_reg <= 1'b0;
            run_reg   <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < 4; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            fill_reg  <= fill_next;
            warm_reg  <= warm_next;
            peak_reg  <= peak_next;
            armed_reg <= armed_next;
            run_reg   <= run_next;
        end
    end

endmodule

// ----- sv/qrs_rate.sv -----
// qrs_rate: per-window beat counter, count history with running sum, bpm and flags.
// Depends on qrs_pkg.
module qrs_rate #(
    parameter int RATE_WINDOWS = 5,
    parameter int COUNT_BITS   = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               beat_inc,
    input  qrs_pkg::cfg_regs_t cfg,
    output qrs_pkg::rate_res_t rate
);
    localparam int IW    = $clog2(RATE_WINDOWS + 1);
    localparam int HW    = (RATE_WINDOWS > 1) ? $clog2(RATE_WINDOWS) : 1;
    localparam int SUMW  = COUNT_BITS + $clog2(RATE_WINDOWS + 1);
    localparam int P6W   = SUMW + 3;
    localparam int BW    = qrs_pkg::BPM_W;
    localparam int EXT_W = (P6W > BW) ? P6W : BW;

    logic [COUNT_BITS-1:0] hist_reg [RATE_WINDOWS];
    logic [COUNT_BITS-1:0] beats_reg;
    logic [SUMW-1:0]       sum_reg, sum_next;
    logic [IW-1:0]         idx_reg, idx_eff;
    logic [IW-1:0]         ticks_reg;
    logic [HW-1:0]         hsel;
    logic [COUNT_BITS-1:0] hist_old;
    logic                  full;
    logic [EXT_W-1:0]      bpm_wide;
    logic [BW-1:0]         bpm;
    logic                  low;

    // History slot for this tick and running-sum update
    assign idx_eff  = (idx_reg >= IW'(RATE_WINDOWS)) ? '0 : idx_reg;
    assign hsel     = idx_eff[HW-1:0];
    assign hist_old = hist_reg[hsel];
    assign sum_next = sum_reg - SUMW'(hist_old) + SUMW'(beats_reg);
    assign full     = ticks_reg >= IW'(RATE_WINDOWS - 1);

    // bpm = 6 * sum, saturated
    assign bpm_wide = (EXT_W'(sum_next) << 2) + (EXT_W'(sum_next) << 1);
    assign bpm      = (bpm_wide > EXT_W'(qrs_pkg::BPM_MAX)) ? qrs_pkg::BPM_MAX
                                                            : bpm_wide[BW-1:0];
    assign low      = bpm <= cfg.rate_low;

    always_comb
    begin
        rate = '0;
        if (full)
        begin
            rate.valid     = 1'b1;
            rate.bpm       = bpm;
            rate.low_flag  = low;
            rate.high_flag = !low && (bpm >= cfg.rate_high);
        end
    end

    // Counters and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RATE_WINDOWS; i++)
            begin
                hist_reg[i] <= '0;
            end
            beats_reg <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
            ticks_reg <= '0;
        end
        else if (tick)
        begin
            hist_reg[hsel] <= beats_reg;
            sum_reg        <= sum_next;
            idx_reg        <= (idx_eff == IW'(RATE_WINDOWS - 1)) ? '0 : idx_eff + 1'b1;
            beats_reg      <= '0;
            if (!full)
            begin
                ticks_reg <= ticks_reg + 1'b1;
            end
        end
        else if (beat_inc && (beats_reg != '1))
        begin
            beats_reg <= beats_reg + 1'b1;
        end
    end

endmodule

// ----- sv/qrs_detect_heart_rate_unit.sv -----
// qrs_detect_heart_rate_unit: top level, request/result pipeline and register file.
// Depends on qrs_pkg, qrs_stream_if, qrs_detect and qrs_rate.
//
//   channel  role     payload               transaction
//   req      sink     qrs_pkg::req_t        ECG sample or rate tick
//   res      source   qrs_pkg::res_t        one result per request
//   cfg      sink     qrs_pkg::cfg_wr_t     register write, always ready
//
// One request per cycle sustained while res is not stalled; a result passes
// through the input register, then the result register, before it is on res.
// All detector and rate state is updated as an item leaves the input register.
// Reset clears the valid flags and all detector and rate state and loads the register defaults.
// A stall on res holds the result register; req is accepted only while the
// input register is empty or moving on.
module qrs_detect_heart_rate_unit #(
    parameter int RATE_WINDOWS = 5,
    parameter int COUNT_BITS   = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    qrs_stream_if.sink   req,
    qrs_stream_if.source res,
    qrs_stream_if.sink   cfg
);
    logic               s1_valid_reg;
    qrs_pkg::req_t      s1_data_reg;
    logic               out_valid_reg;
    qrs_pkg::res_t      out_data_reg;
    qrs_pkg::res_t      res_next;
    qrs_pkg::cfg_regs_t cfg_reg;
    qrs_pkg::rate_res_t rate;
    logic               advance;
    logic               step;
    logic               tick;
    logic               beat;

    // Pipeline handshake
    assign advance   = s1_valid_reg && (!out_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || advance;
    assign step      = advance && (s1_data_reg.req_type == qrs_pkg::REQ_SAMPLE);
    assign tick      = advance && (s1_data_reg.req_type == qrs_pkg::REQ_TICK);
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;
    assign cfg.ready = 1'b1;

    qrs_detect u_detect (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (s1_data_reg.sample),
        .cfg    (cfg_reg),
        .beat   (beat)
    );

    qrs_rate #(
        .RATE_WINDOWS (RATE_WINDOWS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_rate (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick     (tick),
        .beat_inc (step && beat),
        .cfg      (cfg_reg),
        .rate     (rate)
    );

    // Result assembly
    always_comb
    begin
        res_next = '0;
        if (s1_data_reg.req_type == qrs_pkg::REQ_SAMPLE)
        begin
            res_next.beat = beat;
        end
        else
        begin
            res_next.rate_valid     = rate.valid;
            res_next.rate_bpm       = rate.bpm;
            res_next.rate_low_flag  = rate.low_flag;
            res_next.rate_high_flag = rate.high_flag;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_data_reg <= req.data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || res.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= res_next;
        end
    end

    // Register file; writes to unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warmup_count <= qrs_pkg::WARMUP_RST;
            cfg_reg.run_length   <= qrs_pkg::RUN_LEN_RST;
            cfg_reg.rate_low     <= qrs_pkg::RATE_LOW_RST;
            cfg_reg.rate_high    <= qrs_pkg::RATE_HIGH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                qrs_pkg::CFG_WARMUP_COUNT:
                    cfg_reg.warmup_count <= cfg.data.wdata[qrs_pkg::WARM_W-1:0];
                qrs_pkg::CFG_RUN_LENGTH:
                    cfg_reg.run_length <= cfg.data.wdata[qrs_pkg::RUN_W-1:0];
                qrs_pkg::CFG_RATE_LOW:
                    cfg_reg.rate_low <= cfg.data.wdata[qrs_pkg::BPM_W-1:0];
                qrs_pkg::CFG_RATE_HIGH:
                    cfg_reg.rate_high <= cfg.data.wdata[qrs_pkg::BPM_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A result is either a beat report or a rate report, never both
    a_beat_xor_rate: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.data.beat && res.data.rate_valid))
        else $error("beat and rate_valid set in one result");

    // Rate flags only with a valid rate, and never both
    a_flags_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.data.rate_low_flag || res.data.rate_high_flag)
        |-> res.data.rate_valid && !(res.data.rate_low_flag && res.data.rate_high_flag))
        else $error("rate flags inconsistent");

    // An item held in the input register is not dropped while the output stalls
    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("input register lost a transaction");

    // Leaving the input register always fills the result register
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded");

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for qrs_detect_heart_rate_unit (QRS scoring and rate meter).
// Depends on qrs_pkg, qrs_stream_if and the unit's RTL; a cycle-free predictor models results.
`timescale 1ns / 100ps

module tb_top;

    localparam int RATE_WINDOWS   = 5;
    localparam int COUNT_BITS     = 8;
    localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 1000;

    // Directed stimulus rows
    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_TICK,
        ROW_WRITE
    } row_kind_e;

    typedef struct packed {
        row_kind_e           kind;
        qrs_pkg::cfg_index_e reg_idx;
        logic [15:0]         value;
        logic                typed;
        qrs_pkg::res_t       want;
    } dir_row_t;

    localparam qrs_pkg::res_t NO_EVENT = '0;
    localparam qrs_pkg::res_t RATE_ZERO_LOW = '{beat: 1'b0, rate_valid: 1'b1, rate_bpm: '0,
                                                rate_low_flag: 1'b1, rate_high_flag: 1'b0};

    // Typed rows: tick before five windows, window fill, warm-up, first valid rate.
    // Untyped rows run a full-scale QRS pattern with detection enabled.
    localparam dir_row_t DIRECTED [24] = '{
        '{ROW_TICK,   qrs_pkg::CFG_WARMUP_COUNT, 16'h0000, 1'b1, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b1, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b1, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b1, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b1, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h0000, 1'b1, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b1, NO_EVENT},
        '{ROW_TICK,   qrs_pkg::CFG_WARMUP_COUNT, 16'hFFFF, 1'b1, NO_EVENT},
        '{ROW_TICK,   qrs_pkg::CFG_WARMUP_COUNT, 16'h1234, 1'b1, NO_EVENT},
        '{ROW_TICK,   qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b1, NO_EVENT},
        '{ROW_TICK,   qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b1, RATE_ZERO_LOW},
        '{ROW_WRITE,  qrs_pkg::CFG_WARMUP_COUNT, 16'h0000, 1'b0, NO_EVENT},
        '{ROW_WRITE,  qrs_pkg::CFG_RUN_LENGTH,   16'h0001, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h7FFF, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h8000, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'h0001, 1'b0, NO_EVENT},
        '{ROW_SAMPLE, qrs_pkg::CFG_WARMUP_COUNT, 16'hFFFF, 1'b0, NO_EVENT},
        '{ROW_TICK,   qrs_pkg::CFG_WARMUP_COUNT, 16'h0000, 1'b0, NO_EVENT}
    };

    logic clk;
    logic rst_n;

    qrs_stream_if #(.T(qrs_pkg::req_t))    req_if ();
    qrs_stream_if #(.T(qrs_pkg::res_t))    res_if ();
    qrs_stream_if #(.T(qrs_pkg::cfg_wr_t)) cfg_if ();

    qrs_detect_heart_rate_unit #(
        .RATE_WINDOWS (RATE_WINDOWS),
        .COUNT_BITS   (COUNT_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Expected results, oldest first
    qrs_pkg::res_t pending_results [$];
    int   fail_count   = 0;
    int   items_sent   = 0;
    int   quiet_cycles = 0;
    bit   idle_allowed = 1'b1;
    bit   idle_on      = 1'b1;

    // Predictor state and register copy
    qrs_pkg::cfg_regs_t    regs_copy = '{warmup_count: qrs_pkg::WARMUP_RST,
                                         run_length:   qrs_pkg::RUN_LEN_RST,
                                         rate_low:     qrs_pkg::RATE_LOW_RST,
                                         rate_high:    qrs_pkg::RATE_HIGH_RST};
    logic signed [qrs_pkg::SAMPLE_BITS-1:0] taps [4] = '{default: '0};
    int                             taps_filled = 0;
    logic [qrs_pkg::WARMCNT_W-1:0]  warm_seen   = '0;
    logic [qrs_pkg::SCORE_W-1:0]    peak_score  = '0;
    bit                             is_armed    = 1'b0;
    logic [qrs_pkg::RUN_W-1:0]      run_seen    = '0;
    logic [COUNT_BITS-1:0]          beats_now   = '0;
    logic [COUNT_BITS-1:0]          beat_hist [RATE_WINDOWS] = '{default: '0};
    int                             hist_ptr    = 0;
    int                             ticks_held  = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint mag_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the detector / rate meter by one request and return its result
    function automatic qrs_pkg::res_t detect_and_rate(qrs_pkg::req_t item);
        qrs_pkg::res_t r;
        longint        s0, s1, s2, s3, s4;
        longint        score;
        int unsigned   sum;
        int unsigned   bpm;
        r = '0;
        if (item.req_type == qrs_pkg::REQ_SAMPLE)
        begin
            // window still filling
            if (taps_filled < 4)
            begin
                taps[taps_filled] = item.sample;
                taps_filled++;
                return r;
            end
            s0 = taps[0];
            s1 = taps[1];
            s2 = taps[2];
            s3 = taps[3];
            s4 = item.sample;
            taps[0] = taps[1];
            taps[1] = taps[2];
            taps[2] = taps[3];
            taps[3] = item.sample;
            score = mag_of(s2 - s0) + 2 * mag_of(s3 - s1) + mag_of(s4 - s2)
                  + mag_of(s0 - 2 * s2 + s4);
            if (score > longint'(peak_score))
                peak_score = qrs_pkg::SCORE_W'(score);
            if (warm_seen <= regs_copy.warmup_count)
            begin
                warm_seen++;
                return r;
            end
            // armed and at or above 0.1 max: extend the run
            if (10 * score >= longint'(peak_score) && is_armed)
            begin
                if (run_seen < qrs_pkg::RUN_MAX)
                    run_seen++;
                if (run_seen == regs_copy.run_length)
                begin
                    run_seen = '0;
                    is_armed = 1'b0;
                    if (beats_now < COUNT_MAX)
                        beats_now++;
                    r.beat = 1'b1;
                    return r;
                end
            end
            else
            begin
                run_seen = '0;
                is_armed = 1'b0;
            end
            // at or above 0.8 max: arm
            if (10 * score >= 8 * longint'(peak_score) && !is_armed)
                is_armed = 1'b1;
            return r;
        end
        // rate tick: close the current window
        beat_hist[hist_ptr] = beats_now;
        beats_now = '0;
        hist_ptr = (hist_ptr + 1) % RATE_WINDOWS;
        if (ticks_held + 1 < RATE_WINDOWS)
        begin
            ticks_held++;
            return r;
        end
        sum = 0;
        for (int w = 0; w < RATE_WINDOWS; w++)
            sum += beat_hist[w];
        bpm = sum * 6;
        if (bpm > qrs_pkg::BPM_MAX)
            bpm = qrs_pkg::BPM_MAX;
        r.rate_valid = 1'b1;
        r.rate_bpm   = qrs_pkg::BPM_W'(bpm);
        if (bpm <= regs_copy.rate_low)
            r.rate_low_flag = 1'b1;
        else if (bpm >= regs_copy.rate_high)
            r.rate_high_flag = 1'b1;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Result monitor
    always @(posedge clk)
    begin
        qrs_pkg::res_t got;
        qrs_pkg::res_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.data;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("beat", want.beat, got.beat);
                check_field("rate_valid", want.rate_valid, got.rate_valid);
                check_field("rate_bpm", want.rate_bpm, got.rate_bpm);
                check_field("rate_low_flag", want.rate_low_flag, got.rate_low_flag);
                check_field("rate_high_flag", want.rate_high_flag, got.rate_high_flag);
            end
        end
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result-side back-pressure in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // One request transaction; valid stays high afterwards until the next call or a drain
    task automatic send_req(input qrs_pkg::req_t item, input bit typed,
                            input qrs_pkg::res_t typed_want);
        int            gap;
        qrs_pkg::res_t want;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        want = detect_and_rate(item);
        pending_results.push_back(typed ? typed_want : want);
        items_sent++;
    endtask

    task automatic push_sample(input int v);
        send_req(qrs_pkg::req_t'{req_type: qrs_pkg::REQ_SAMPLE, sample: 16'(v)},
                 1'b0, NO_EVENT);
    endtask

    // sample field of a tick is don't-care, so randomize it
    task automatic push_tick();
        send_req(qrs_pkg::req_t'{req_type: qrs_pkg::REQ_TICK, sample: 16'($urandom)},
                 1'b0, NO_EVENT);
    endtask

    // Stop sending and wait until every expected result is back
    task automatic settle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input qrs_pkg::cfg_index_e idx,
                             input logic [qrs_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= qrs_pkg::cfg_wr_t'{index: idx, wdata: val};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            qrs_pkg::CFG_WARMUP_COUNT:
                regs_copy.warmup_count = val[qrs_pkg::WARM_W-1:0];
            qrs_pkg::CFG_RUN_LENGTH:
                regs_copy.run_length   = val[qrs_pkg::RUN_W-1:0];
            qrs_pkg::CFG_RATE_LOW:
                regs_copy.rate_low     = val[qrs_pkg::BPM_W-1:0];
            qrs_pkg::CFG_RATE_HIGH:
                regs_copy.rate_high    = val[qrs_pkg::BPM_W-1:0];
            default:          ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_regs(input int warm, input int run, input int low, input int high);
        settle();
        write_reg(qrs_pkg::CFG_WARMUP_COUNT, qrs_pkg::CFG_DATA_W'(warm));
        write_reg(qrs_pkg::CFG_RUN_LENGTH, qrs_pkg::CFG_DATA_W'(run));
        write_reg(qrs_pkg::CFG_RATE_LOW, qrs_pkg::CFG_DATA_W'(low));
        write_reg(qrs_pkg::CFG_RATE_HIGH, qrs_pkg::CFG_DATA_W'(high));
    endtask

    // QRS-like burst: ++-- pattern of large magnitudes gives near-maximum scores
    task automatic spike(input int len, input int lo);
        int ph;
        int v;
        ph = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            if (((i + ph) % 4) < 2)
                v = $urandom_range(lo, 32767);
            else
                v = -int'($urandom_range(lo, 32768));
            push_sample(v);
        end
    endtask

    // Random ECG-like traffic: baseline with ticks, QRS bursts, noise and broken bursts
    task automatic random_stream(input int n, input int run_min);
        int stop;
        int pick;
        int len;
        int v;
        stop = items_sent + n;
        while (items_sent < stop)
        begin
            idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                len = $urandom_range(5, 30);
                repeat (len)
                begin
                    if ($urandom_range(0, 24) == 0)
                        push_tick();
                    else
                    begin
                        v = int'($urandom_range(0, 4000)) - 2000;
                        push_sample(v);
                    end
                end
            end
            else if (pick < 85)
                spike($urandom_range(run_min, run_min + 12),
                      $urandom_range(0, 1) ? 26000 : 12000);
            else if (pick < 93)
            begin
                len = $urandom_range(1, 8);
                repeat (len) push_sample(int'($urandom));
            end
            else
            begin
                // truncated burst followed by ticks
                spike($urandom_range(1, 2), 20000);
                len = $urandom_range(1, 3);
                repeat (len) push_tick();
            end
        end
    endtask

    // Main sequence
    initial
    begin
        dir_row_t cur;
        int       row;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        rst_n        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        for (row = 0; row < $size(DIRECTED); row++)
        begin
            cur = DIRECTED[row];
            case (cur.kind)
                ROW_WRITE:
                begin
                    settle();
                    write_reg(cur.reg_idx, cur.value[qrs_pkg::CFG_DATA_W-1:0]);
                end
                ROW_TICK:
                    send_req(qrs_pkg::req_t'{req_type: qrs_pkg::REQ_TICK, sample: cur.value},
                             cur.typed, cur.want);
                default:
                    send_req(qrs_pkg::req_t'{req_type: qrs_pkg::REQ_SAMPLE, sample: cur.value},
                             cur.typed, cur.want);
            endcase
        end

        // long warm-up, then lowered below the count already reached
        set_regs(1023, 4, 80, 88);
        random_stream(200, 6);
        settle();
        write_reg(qrs_pkg::CFG_WARMUP_COUNT, qrs_pkg::CFG_DATA_W'(3));
        random_stream(200, 6);

        // single-score runs: overflow the per-window beat count, then report it
        set_regs(0, 1, 0, 7650);
        spike(540, 31000);
        repeat (5) push_tick();
        random_stream(60, 2);

        // longest run, low flag always set
        set_regs(5, 15, 7650, 0);
        random_stream(150, 16);

        // run length zero never confirms a beat
        set_regs(10, 0, 40, 40);
        random_stream(100, 4);

        // final stretch without idling
        set_regs(20, 2, 30, 60);
        idle_allowed = 1'b0;
        idle_on      = 1'b0;
        random_stream(180, 3);

        settle();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/qrs_pkg.sv
sv/qrs_stream_if.sv
sv/qrs_score.sv
sv/qrs_detect.sv
sv/qrs_rate.sv
sv/qrs_detect_heart_rate_unit.sv
sim/tb_top.sv
